/* rtl/smx_pkg.sv */
// ============================================================================
// smx_pkg : shared types and constants for the int8 softmax block
// Transaction payloads, controller commands, datapath status and the fixed
// constants of the table lookup and the normalising divider.
// ============================================================================
package smx_pkg;

   // Defaults for the top-level parameters
   localparam int MAX_ELEMS_DEF   = 64;
   localparam int TABLE_DEPTH_DEF = 256;

   // Table index offset: entry a stands for the difference a - 255
   localparam int DIFF_OFFSET = 255;

   // Width of the running sum of looked-up exponentials
   localparam int TOTAL_W = 22;

   // Quotient bits produced by the divider, one per step
   localparam int DIV_STEPS = 16;

   // Saturated probability
   localparam logic [15:0] PROB_MAX = 16'hFFFF;

   // Operation codes of an input transaction
   localparam logic OP_TABLE_WRITE = 1'b0;
   localparam logic OP_LOGIT       = 1'b1;

   // Input transaction
   typedef struct packed {
      logic               operation;
      logic [7:0]         table_address;
      logic [15:0]        table_value;
      logic signed [7:0]  logit;
      logic               last_logit;
   } req_type;

   // Result transaction
   typedef struct packed {
      logic [15:0] probability;
      logic [5:0]  element_index;
      logic        last_result;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic take;       // input transaction accepted this cycle
      logic rd_buf;     // read logit buffer at element index
      logic rd_tab;     // read exponential table at buffered logit
      logic acc;        // add table word to the running total
      logic div_init;   // load divider from table word
      logic div_step;   // one restoring division step
      logic load_out;   // load result register
      logic next_k;     // advance element index
      logic clr_k;      // clear element index
      logic clr_vec;    // end of vector: clear max, count and total
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic start;      // offered transaction is a logit marked last
      logic k_last;     // element index is the final held element
      logic div_last;   // current division step is the final one
      logic out_free;   // result register can take a new value
   } status_type;

endpackage

/* rtl/int8_softmax_lookup_table.sv */
// ============================================================================
// int8_softmax_lookup_table : softmax over int8 logits via exponential table
// Buffers a vector of logits, then emits one Q0.16 probability per element.
// ============================================================================
// Usage:
//   req_* carries one transaction per accept (req_valid high, req_stall low).
//   A table-write transaction stores one Q1.15 word of the exponential table;
//   the table must be loaded before a vector is normalised. A logit
//   transaction is buffered (up to MAX_ELEMS; extras are dropped) and folds
//   into the running maximum. Table writes and logits are accepted back to
//   back while the block is idle. A logit marked last starts output: the n
//   held elements are summed in turn (buffer read, table read, add), then
//   each is normalised in turn (two memory reads, divider load, 16 one-bit
//   restoring division steps, result load); req_stall stays high until the
//   final result has been loaded into the output register. rsp_* presents
//   results in input order from a single output register; a stall on
//   rsp_stall holds the result and delays the next load.
//   After reset the table content is unknown, the buffer is empty and the
//   maximum is at its lowest value; the table is not cleared.
// ============================================================================
module int8_softmax_lookup_table #(
   parameter int MAX_ELEMS   = smx_pkg::MAX_ELEMS_DEF,
   parameter int TABLE_DEPTH = smx_pkg::TABLE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  smx_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output smx_pkg::rsp_type  rsp_data
);

   smx_pkg::cmd_type    cmd;
   smx_pkg::status_type status;

   // Sequencer
   smx_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   // Memories, arithmetic and result register
   smx_dpath #(
      .MAX_ELEMS   (MAX_ELEMS),
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // A pending result is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid || !rsp_stall))
      else $error("result register loaded while a result is pending");

   // The final result of a vector returns the block to accepting input
   assert property (@(posedge clock) disable iff (reset)
      (cmd.load_out && status.k_last) |=> !req_stall)
      else $error("block not idle after the final result");

   // At most one datapath step per cycle
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.take, cmd.rd_buf, cmd.rd_tab, cmd.acc, cmd.div_init,
                cmd.div_step, cmd.load_out}))
      else $error("conflicting datapath commands");

   // Input is only taken while the block accepts transactions
   assert property (@(posedge clock) disable iff (reset)
      cmd.take |-> (req_valid && !req_stall))
      else $error("input taken while stalled");

endmodule

/* rtl/smx_ctrl.sv */
// ============================================================================
// smx_ctrl : sequencer for the int8 softmax block
// Walks the held elements twice after the last logit: once to sum the
// looked-up exponentials, once to normalise each one through the divider.
// ============================================================================
module smx_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  smx_pkg::status_type   status,
   output logic                  req_stall,
   output smx_pkg::cmd_type      cmd
);

   typedef enum logic [8:0] {
      ST_IDLE     = 9'b000000001,
      ST_SUM_BUF  = 9'b000000010,
      ST_SUM_TAB  = 9'b000000100,
      ST_SUM_ACC  = 9'b000001000,
      ST_NRM_BUF  = 9'b000010000,
      ST_NRM_TAB  = 9'b000100000,
      ST_NRM_INIT = 9'b001000000,
      ST_NRM_DIV  = 9'b010000000,
      ST_NRM_OUT  = 9'b100000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state and command decode
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.take  = req_valid;
            if (req_valid && status.start) begin
               state_in = ST_SUM_BUF;
            end
         end
         ST_SUM_BUF: begin
            cmd.rd_buf = 1'b1;
            state_in   = ST_SUM_TAB;
         end
         ST_SUM_TAB: begin
            cmd.rd_tab = 1'b1;
            state_in   = ST_SUM_ACC;
         end
         ST_SUM_ACC: begin
            cmd.acc = 1'b1;
            if (status.k_last) begin
               cmd.clr_k = 1'b1;
               state_in  = ST_NRM_BUF;
            end else begin
               cmd.next_k = 1'b1;
               state_in   = ST_SUM_BUF;
            end
         end
         ST_NRM_BUF: begin
            cmd.rd_buf = 1'b1;
            state_in   = ST_NRM_TAB;
         end
         ST_NRM_TAB: begin
            cmd.rd_tab = 1'b1;
            state_in   = ST_NRM_INIT;
         end
         ST_NRM_INIT: begin
            cmd.div_init = 1'b1;
            state_in     = ST_NRM_DIV;
         end
         ST_NRM_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_NRM_OUT;
            end
         end
         ST_NRM_OUT: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               if (status.k_last) begin
                  cmd.clr_k   = 1'b1;
                  cmd.clr_vec = 1'b1;
                  state_in    = ST_IDLE;
               end else begin
                  cmd.next_k = 1'b1;
                  state_in   = ST_NRM_BUF;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/smx_dpath.sv */
// ============================================================================
// smx_dpath : datapath of the int8 softmax block
// Logit buffer and exponential table memories, running maximum, element
// count, running total, restoring divider and the result register.
// ============================================================================
module smx_dpath #(
   parameter int MAX_ELEMS   = smx_pkg::MAX_ELEMS_DEF,
   parameter int TABLE_DEPTH = smx_pkg::TABLE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  smx_pkg::req_type      req_data,
   input  logic                  rsp_stall,
   input  smx_pkg::cmd_type      cmd,
   output smx_pkg::status_type   status,
   output logic                  rsp_valid,
   output smx_pkg::rsp_type      rsp_data
);

   localparam int BUF_AW  = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
   localparam int CNT_W   = $clog2(MAX_ELEMS + 1);
   localparam int TAB_AW  = $clog2(TABLE_DEPTH);
   localparam int DIV_CW  = $clog2(smx_pkg::DIV_STEPS);
   localparam int TOT_W   = smx_pkg::TOTAL_W;

   // Memories
   logic signed [7:0] buf_mem [MAX_ELEMS];
   logic [15:0]       exp_mem [TABLE_DEPTH];

   // Control registers
   logic [CNT_W-1:0]  count_ff, count_in;
   logic signed [7:0] max_ff, max_in;
   logic [TOT_W-1:0]  total_ff, total_in;
   logic [CNT_W-1:0]  k_ff, k_in;
   logic [DIV_CW-1:0] div_cnt_ff, div_cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Payload registers
   logic signed [7:0] buf_q_ff;
   logic [15:0]       exp_q_ff;
   logic [TOT_W-1:0]  rem_ff;
   logic [15:0]       quot_ff;
   logic              sat_ff;
   smx_pkg::rsp_type  rsp_ff;

   logic              store_logit;
   logic              table_write;
   logic signed [9:0] diff;
   logic [TAB_AW-1:0] tab_idx;
   logic [TOT_W:0]    rem_sh;
   logic [TOT_W:0]    tot_ext;
   logic              rem_ge;
   logic [15:0]       prob;

   // Input decode: logits are dropped once the buffer is full
   assign store_logit = cmd.take && (req_data.operation == smx_pkg::OP_LOGIT)
                        && (count_ff < CNT_W'(MAX_ELEMS));
   assign table_write = cmd.take && (req_data.operation == smx_pkg::OP_TABLE_WRITE);

   // Table index: logit minus maximum, offset into 0..255
   assign diff    = 10'(buf_q_ff) - 10'(max_ff) + 10'(smx_pkg::DIFF_OFFSET);
   assign tab_idx = diff[TAB_AW-1:0];

   // Restoring division step
   assign rem_sh  = {rem_ff, 1'b0};
   assign tot_ext = {1'b0, total_ff};
   assign rem_ge  = (rem_sh >= tot_ext);

   assign prob = sat_ff ? smx_pkg::PROB_MAX : quot_ff;

   // Next values of control registers
   always_comb begin
      count_in = count_ff;
      max_in   = max_ff;
      total_in = total_ff;
      if (cmd.clr_vec) begin
         count_in = '0;
         max_in   = -8'sd128;
         total_in = '0;
      end else begin
         if (store_logit) begin
            count_in = count_ff + 1'b1;
            if (req_data.logit > max_ff) begin
               max_in = req_data.logit;
            end
         end
         if (cmd.acc) begin
            total_in = total_ff + TOT_W'(exp_q_ff);
         end
      end

      k_in = k_ff;
      priority if (cmd.clr_k) begin
         k_in = '0;
      end else if (cmd.next_k) begin
         k_in = k_ff + 1'b1;
      end

      div_cnt_in = div_cnt_ff;
      priority if (cmd.div_init) begin
         div_cnt_in = '0;
      end else if (cmd.div_step) begin
         div_cnt_in = div_cnt_ff + 1'b1;
      end

      rsp_valid_in = rsp_valid_ff;
      priority if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         max_ff       <= -8'sd128;
         total_ff     <= '0;
         k_ff         <= '0;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         max_ff       <= max_in;
         total_ff     <= total_in;
         k_ff         <= k_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Logit buffer: write at count, registered read at element index
   always_ff @(posedge clock) begin
      if (store_logit) begin
         buf_mem[count_ff[BUF_AW-1:0]] <= req_data.logit;
      end
      if (cmd.rd_buf) begin
         buf_q_ff <= buf_mem[k_ff[BUF_AW-1:0]];
      end
   end

   // Exponential table: write from input, registered read at lookup index
   always_ff @(posedge clock) begin
      if (table_write) begin
         exp_mem[req_data.table_address[TAB_AW-1:0]] <= req_data.table_value;
      end
      if (cmd.rd_tab) begin
         exp_q_ff <= exp_mem[tab_idx];
      end
   end

   // Divider: quotient saturates when the word is not below the total
   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         rem_ff  <= TOT_W'(exp_q_ff);
         sat_ff  <= (TOT_W'(exp_q_ff) >= total_ff);
         quot_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff  <= rem_ge ? TOT_W'(rem_sh - tot_ext) : rem_sh[TOT_W-1:0];
         quot_ff <= {quot_ff[14:0], rem_ge};
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_ff.probability   <= prob;
         rsp_ff.element_index <= 6'(k_ff);
         rsp_ff.last_result   <= status.k_last;
      end
   end

   // Status to controller
   assign status.start    = (req_data.operation == smx_pkg::OP_LOGIT) && req_data.last_logit;
   assign status.k_last   = (CNT_W'(k_ff + 1'b1) == count_ff);
   assign status.div_last = (div_cnt_ff == DIV_CW'(smx_pkg::DIV_STEPS - 1));
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* test/int8_softmax_lookup_table_checker.sv */
`timescale 1ns / 100ps
// ============================================================================
// int8_softmax_lookup_table_checker : prediction and checking of probabilities
// Watches both channels of the softmax block. Every accepted input transaction
// updates a local copy of the exponential table, the logit buffer and the
// running maximum. A logit marked last turns the buffer into a list of expected
// probabilities, which are matched in order against accepted results.
// ============================================================================
module int8_softmax_lookup_table_checker #(
   parameter int MAX_ELEMS   = smx_pkg::MAX_ELEMS_DEF,
   parameter int TABLE_DEPTH = smx_pkg::TABLE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  smx_pkg::req_type  req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  smx_pkg::rsp_type  rsp_data,
   output int unsigned       fail_count,
   output int unsigned       pending_count,
   output int unsigned       checked_count
);

   localparam logic signed [7:0] LOGIT_MIN = -8'sd128;

   // Local copy of the block's state
   logic [15:0]       exp_lut [TABLE_DEPTH];
   logic signed [7:0] held_logit [MAX_ELEMS];
   logic signed [7:0] vec_max;
   int unsigned       held_count;

   // Probabilities still to come, oldest first
   smx_pkg::rsp_type  expected_probs [$];
   int unsigned       queued_count;

   // Outstanding probabilities, settled once both sides of an edge are done
   assign pending_count = queued_count - checked_count;

   // Table word for a logit, indexed by its distance below the maximum
   function automatic logic [15:0] lookup_exp(logic signed [7:0] x);
      int idx;
      idx = int'(x) - int'(vec_max) + smx_pkg::DIFF_OFFSET;
      return exp_lut[idx[7:0]];
   endfunction

   // Sum the looked-up words, then queue one probability per held logit
   task automatic normalise_vector();
      logic [21:0]      exp_sum;
      logic [15:0]      exp_word;
      logic [31:0]      quotient;
      smx_pkg::rsp_type prob_item;
      exp_sum = '0;
      for (int k = 0; k < held_count; k++) begin
         exp_sum = exp_sum + 22'(lookup_exp(held_logit[k]));
      end
      for (int k = 0; k < held_count; k++) begin
         exp_word = lookup_exp(held_logit[k]);
         if (exp_sum == '0) begin
            // divider answers all ones on a zero divisor
            prob_item.probability = smx_pkg::PROB_MAX;
         end else begin
            quotient = {exp_word, 16'h0000} / {10'd0, exp_sum};
            prob_item.probability = (quotient > 32'h0000_FFFF) ? smx_pkg::PROB_MAX
                                                               : quotient[15:0];
         end
         prob_item.element_index = 6'(k);
         prob_item.last_result   = (k == held_count - 1);
         expected_probs.insert(expected_probs.size(), prob_item);
         queued_count++;
      end
      vec_max    = LOGIT_MIN;
      held_count = 0;
   endtask

   // Input side: fold each accepted transaction into the prediction
   always @(posedge clock) begin
      if (reset) begin
         vec_max      = LOGIT_MIN;
         held_count   = 0;
         queued_count = 0;
      end else if (req_valid && !req_stall) begin
         if (req_data.operation == smx_pkg::OP_TABLE_WRITE) begin
            exp_lut[req_data.table_address] = req_data.table_value;
         end else begin
            // elements beyond a full buffer are dropped
            if (held_count < MAX_ELEMS) begin
               held_logit[held_count] = req_data.logit;
               if ($signed(req_data.logit) > vec_max) begin
                  vec_max = req_data.logit;
               end
               held_count++;
            end
            if (req_data.last_logit) begin
               normalise_vector();
            end
         end
      end
   end

   // Result side: compare against the oldest expected probability
   always @(posedge clock) begin
      smx_pkg::rsp_type want;
      if (reset) begin
         fail_count    = 0;
         checked_count = 0;
      end else if (rsp_valid && !rsp_stall) begin
         if (expected_probs.size() == 0) begin
            $error("unexpected result: probability %0d, element_index %0d, last_result %0d",
                   rsp_data.probability, rsp_data.element_index, rsp_data.last_result);
            fail_count++;
         end else begin
            want = expected_probs.pop_front();
            if (rsp_data.probability !== want.probability) begin
               $error("probability: expected %0d, actual %0d",
                      want.probability, rsp_data.probability);
               fail_count++;
            end
            if (rsp_data.element_index !== want.element_index) begin
               $error("element_index: expected %0d, actual %0d",
                      want.element_index, rsp_data.element_index);
               fail_count++;
            end
            if (rsp_data.last_result !== want.last_result) begin
               $error("last_result: expected %0d, actual %0d",
                      want.last_result, rsp_data.last_result);
               fail_count++;
            end
            checked_count++;
         end
      end
   end

endmodule

/* test/int8_softmax_lookup_table_test.sv */
`timescale 1ns / 100ps
// ============================================================================
// int8_softmax_lookup_table_test : top level of the softmax block testbench
// Loads the exponential table, runs a short directed set of vectors and then
// random vectors mixed with table rewrites, under bursty input and a stalling
// result side. A checker beside the block predicts and compares every result.
// ============================================================================
module int8_softmax_lookup_table_test;

   localparam int          CLK_HALF      = 6;
   localparam int          RESET_CYCLES  = 6;
   localparam int          RANDOM_ITEMS  = 180;
   localparam int          LONG_HOLD     = 600;
   localparam int          DRAIN_CYCLES  = 300;
   localparam int unsigned CYCLE_LIMIT   = 500000;
   localparam logic signed [7:0] LOGIT_MIN = -8'sd128;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   smx_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   smx_pkg::rsp_type rsp_data;

   int unsigned fail_count;
   int unsigned pending_count;
   int unsigned checked_count;

   // Stimulus bookkeeping
   int unsigned burst_left     = 0;
   int unsigned items_sent     = 0;
   int unsigned vectors_sent   = 0;
   int unsigned overflow_sent  = 0;
   int unsigned cycle_count    = 0;
   bit          long_hold_req  = 1'b0;
   bit          long_hold_done = 1'b0;

   // Clock
   always begin
      #(CLK_HALF) clock = 1'b1;
      #(CLK_HALF) clock = 1'b0;
   end

   int8_softmax_lookup_table u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   int8_softmax_lookup_table_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .checked_count (checked_count)
   );

   // Offer one transaction in bursts; called and returns at a falling edge
   task automatic send_item(input smx_pkg::req_type item);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_valid = 1'b1;
      req_data  = item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
      items_sent++;
      @(negedge clock);
   endtask

   // Table write with junk in the logit fields
   task automatic write_exp(input logic [7:0] addr, input logic [15:0] value);
      smx_pkg::req_type item;
      item.operation     = smx_pkg::OP_TABLE_WRITE;
      item.table_address = addr;
      item.table_value   = value;
      item.logit         = 8'($urandom);
      item.last_logit    = 1'($urandom);
      send_item(item);
   endtask

   // Logit with junk in the table fields
   task automatic send_logit(input logic signed [7:0] x, input logic last);
      smx_pkg::req_type item;
      item.operation     = smx_pkg::OP_LOGIT;
      item.table_address = 8'($urandom);
      item.table_value   = 16'($urandom_range(0, 32768));
      item.logit         = x;
      item.last_logit    = last;
      send_item(item);
      if (last) vectors_sent++;
   endtask

   function automatic logic [15:0] pick_exp_value();
      case ($urandom_range(0, 7))
         0: begin
            return 16'd0;
         end
         1: begin
            return 16'd32768;
         end
         default: begin
            return 16'($urandom_range(0, 32767));
         end
      endcase
   endfunction

   // Hold the input idle until every expected probability has arrived
   task automatic wait_drained();
      req_valid  = 1'b0;
      burst_left = 0;
      while (pending_count != 0) @(negedge clock);
   endtask

   // Result side stall pattern, with one long hold when asked
   initial begin : rsp_pacing
      int unsigned kind;
      int unsigned span;
      @(negedge clock);
      forever begin
         if (long_hold_req && !long_hold_done) begin
            rsp_stall = 1'b1;
            repeat (LONG_HOLD) @(negedge clock);
            long_hold_done = 1'b1;
         end else begin
            kind = $urandom_range(0, 9);
            span = $urandom_range(10, 60);
            for (int i = 0; i < span; i++) begin
               if (kind < 3) begin
                  rsp_stall = 1'b0;
               end else if (kind < 8) begin
                  rsp_stall = ($urandom_range(0, 2) == 0);
               end else begin
                  rsp_stall = ((i % 7) < 3);
               end
               @(negedge clock);
            end
         end
      end
   end

   // Watchdog
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $error("timeout after %0d cycles, %0d results outstanding", cycle_count, pending_count);
      $display("end of test: mismatches");
      $finish;
   end

   // Stimulus
   initial begin : stimulus
      int          exp_word;
      int          random_start;
      int          vec_len;
      int          base;
      int          logit_val;
      int unsigned vec_number;
      bit          clustered;
      bit          paused;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Load the whole table with exp(a - 255) in Q1.15 before any lookup
      exp_word = 32768;
      for (int a = 255; a >= 0; a--) begin
         write_exp(8'(a), 16'(exp_word));
         exp_word = (exp_word * 24109) >>> 16;
      end

      // Zero total: the only entry looked up holds zero
      write_exp(8'd255, 16'd0);
      send_logit(8'sd5, 1'b1);
      write_exp(8'd255, 16'd32768);

      // Widest spread: the minimum looks up entry 0, the maximum entry 255
      write_exp(8'd0, 16'd1);
      send_logit(LOGIT_MIN, 1'b0);
      send_logit(8'sd127, 1'b1);

      // Ties at the maximum
      send_logit(8'sd127, 1'b0);
      send_logit(8'sd127, 1'b0);
      send_logit(8'sd127, 1'b1);

      // Lone minimum
      send_logit(LOGIT_MIN, 1'b1);

      // Mixed vector
      send_logit(8'sd0, 1'b0);
      send_logit(-8'sd1, 1'b0);
      send_logit(8'sd1, 1'b0);
      send_logit(LOGIT_MIN, 1'b0);
      send_logit(8'sd100, 1'b1);

      // Random vectors with table rewrites and stray writes
      random_start = items_sent;
      vec_number   = 0;
      paused       = 1'b0;
      while (items_sent - random_start < RANDOM_ITEMS) begin
         if (!long_hold_req && items_sent - random_start >= 30) begin
            long_hold_req = 1'b1;
         end
         if (!paused && items_sent - random_start >= 100) begin
            wait_drained();
            paused = 1'b1;
         end
         if ($urandom_range(0, 19) < 3) begin
            // noise: a few table writes on their own
            repeat ($urandom_range(1, 4)) write_exp(8'($urandom), pick_exp_value());
         end else begin
            vec_number++;
            if (vec_number == 5 || $urandom_range(0, 24) == 0) begin
               vec_len = $urandom_range(60, 70);
            end else begin
               vec_len = $urandom_range(1, 10);
            end
            if (vec_len > smx_pkg::MAX_ELEMS_DEF) overflow_sent++;
            clustered = ($urandom_range(0, 2) != 0);
            base      = int'($urandom_range(0, 255)) - 128;
            for (int k = 0; k < vec_len; k++) begin
               if ($urandom_range(0, 9) == 0) begin
                  write_exp(8'($urandom), pick_exp_value());
               end
               if (clustered) begin
                  logit_val = base - int'($urandom_range(0, 6));
                  if (logit_val < -128) logit_val = -128;
               end else begin
                  logit_val = int'($urandom_range(0, 255)) - 128;
               end
               send_logit(8'(logit_val), k == vec_len - 1);
            end
         end
      end

      // Let every probability arrive, then watch for strays
      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("covered %0d input transactions, %0d vectors (%0d longer than the buffer)",
               items_sent, vectors_sent, overflow_sent);
      $display("%0d probabilities compared, including a %0d-cycle result hold-off",
               checked_count, LONG_HOLD);
      if (fail_count == 0 && pending_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
